/* src/sitoa_pkg.sv */
// Shared constants, types and helpers for the signed integer to ASCII radix unit.
package sitoa_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int MAX_DIGITS  = VALUE_WIDTH;
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int ADDR_W      = $clog2(MAX_DIGITS);
    localparam int DIV_BITS    = 8;
    localparam int DIV_CYCLES  = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
    localparam int PAD_W       = DIV_CYCLES * DIV_BITS;
    localparam int CHUNK_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    localparam int BASE_W  = 5;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 8;

    localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;
    localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MAX   = 5'd16;
    localparam logic [BASE_W-1:0] BASE_DEC   = 5'd10;

    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NUM_OFS = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_HEX_OFS = 8'd55;
    localparam logic [CHAR_W-1:0] CHAR_NONE    = 8'd0;
    localparam logic [DIGIT_W-1:0] DIGIT_NINE  = 4'd9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INVALID,
        ST_DIVIDE,
        ST_STORE,
        ST_SIGN,
        ST_READ,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic store;
        logic emit_sign;
        logic rd;
        logic emit_digit;
        logic emit_invalid;
    } t_cmd;

    typedef struct packed {
        logic base_ok;
        logic chunk_last;
        logic quot_zero;
        logic neg_dec;
        logic cnt_one;
        logic out_free;
    } t_status;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d > DIGIT_NINE) begin
            return ext + CHAR_HEX_OFS;
        end
        return ext + CHAR_NUM_OFS;
    endfunction

endpackage

/* src/sitoa_ctrl.sv */
// Controller state machine sequencing divide, store and emit steps.
module sitoa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sitoa_pkg::t_status i_status,
    output sitoa_pkg::t_cmd   o_cmd
);
    import sitoa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.base_ok ? ST_DIVIDE : ST_INVALID;
                end
            end
            ST_INVALID: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIVIDE: begin
                if (i_status.chunk_last) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: begin
                if (!i_status.quot_zero) begin
                    n_state = ST_DIVIDE;
                end else if (i_status.neg_dec) begin
                    n_state = ST_SIGN;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_SIGN: begin
                if (i_status.out_free) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    n_state = i_status.cnt_one ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = i_rst_n;
                o_cmd.load = i_in_valid;
            end
            ST_INVALID: begin
                o_cmd.emit_invalid = i_status.out_free;
            end
            ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
            end
            ST_STORE: begin
                o_cmd.store = 1'b1;
            end
            ST_SIGN: begin
                o_cmd.emit_sign = i_status.out_free;
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
            end
            ST_OUT: begin
                o_cmd.emit_digit = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* src/sitoa_datapath.sv */
// Datapath: radix register, shift-subtract divider, digit memory and output register.
module sitoa_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [sitoa_pkg::BASE_W-1:0]        i_cfg_number_base,
    input  logic signed [sitoa_pkg::VALUE_WIDTH-1:0] i_signed_value,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [sitoa_pkg::CHAR_W-1:0]        o_character,
    output logic                                o_last_char,
    output logic                                o_base_invalid,
    input  sitoa_pkg::t_cmd                     i_cmd,
    output sitoa_pkg::t_status                  o_status
);
    import sitoa_pkg::*;

    logic [BASE_W-1:0]  r_base;
    logic [PAD_W-1:0]   r_quot;
    logic [PAD_W-1:0]   n_quot;
    logic [BASE_W-1:0]  r_rem;
    logic [BASE_W-1:0]  n_rem;
    logic [CHUNK_W-1:0] r_chunk;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_neg_dec;
    logic [DIGIT_W-1:0] r_rd_digit;
    logic [DIGIT_W-1:0] r_mem [MAX_DIGITS];
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;
    logic               r_inv;

    logic [VALUE_WIDTH-1:0] mag;
    logic [CNT_W-1:0]       cnt_dec;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   out_free;

    assign mag      = i_signed_value[VALUE_WIDTH-1] ? (~i_signed_value + 1'b1) : i_signed_value;
    assign cnt_dec  = r_cnt - CNT_W'(1);
    assign rd_addr  = cnt_dec[ADDR_W-1:0];
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_rem  = r_rem;
        n_quot = r_quot;
        for (int k = 0; k < DIV_BITS; k++) begin
            n_rem  = {n_rem[BASE_W-2:0], n_quot[PAD_W-1]};
            n_quot = {n_quot[PAD_W-2:0], 1'b0};
            if (n_rem >= r_base) begin
                n_rem     = n_rem - r_base;
                n_quot[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
        end else if (i_cfg_valid) begin
            r_base <= i_cfg_number_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_chunk <= '0;
        end else begin
            if (i_cmd.load) begin
                r_cnt   <= '0;
                r_chunk <= '0;
            end else if (i_cmd.div_step) begin
                r_chunk <= r_chunk + CHUNK_W'(1);
            end else if (i_cmd.store) begin
                r_cnt   <= r_cnt + CNT_W'(1);
                r_chunk <= '0;
            end else if (i_cmd.emit_digit) begin
                r_cnt <= cnt_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quot    <= PAD_W'(mag);
            r_rem     <= '0;
            r_neg_dec <= i_signed_value[VALUE_WIDTH-1] && (r_base == BASE_DEC);
        end else if (i_cmd.div_step) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end else if (i_cmd.store) begin
            r_rem <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[r_cnt[ADDR_W-1:0]] <= r_rem[DIGIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_digit <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit || i_cmd.emit_invalid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_invalid) begin
            r_char <= CHAR_NONE;
            r_last <= 1'b1;
            r_inv  <= 1'b1;
        end else if (i_cmd.emit_sign) begin
            r_char <= CHAR_MINUS;
            r_last <= 1'b0;
            r_inv  <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_char <= digit_char(r_rd_digit);
            r_last <= (r_cnt == CNT_W'(1));
            r_inv  <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_character    = r_char;
    assign o_last_char    = r_last;
    assign o_base_invalid = r_inv;

    assign o_status.base_ok    = (r_base >= BASE_MIN) && (r_base <= BASE_MAX);
    assign o_status.chunk_last = (r_chunk == CHUNK_W'(DIV_CYCLES - 1));
    assign o_status.quot_zero  = (r_quot == '0);
    assign o_status.neg_dec    = r_neg_dec;
    assign o_status.cnt_one    = (r_cnt == CNT_W'(1));
    assign o_status.out_free   = out_free;

    a_emit_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_sign || i_cmd.emit_digit || i_cmd.emit_invalid) |-> out_free)
        else $error("emit while output register is occupied");

    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_cnt == '0) && (r_chunk == '0) && (r_rem == '0))
        else $error("load did not clear digit count and remainder");

    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_digit && (r_cnt == CNT_W'(1))) |=> (o_out_valid && o_last_char))
        else $error("final digit not flagged last");

    a_invalid_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_base_invalid) |-> (o_last_char && (o_character == CHAR_NONE)))
        else $error("invalid-base transaction malformed");

    a_remainder_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store |-> (r_rem < r_base))
        else $error("remainder not below radix");

endmodule

/* src/signed_integer_to_ascii_radix_unit.sv */
// Top level of the signed integer to ASCII radix unit.
// Converts one signed 32-bit value per input transaction into its text form, most significant
// character first, one ASCII character per output transaction, in the radix held in the
// number_base register (2..16, reset 10; write only while idle). Each digit comes from a
// shift-subtract divider retiring 8 quotient bits per cycle, then a store step writes it
// to a registered digit memory, from which characters leave one at a time, each waiting for
// a free output register. A negative value in base 10 gets a leading '-'. An invalid radix
// gives a single transaction with base_invalid and last_char set. The next value is taken
// once the last character has been loaded into the output register.
module signed_integer_to_ascii_radix_unit (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [sitoa_pkg::BASE_W-1:0]             i_cfg_number_base,
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic signed [sitoa_pkg::VALUE_WIDTH-1:0] i_signed_value,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic [sitoa_pkg::CHAR_W-1:0]             o_character,
    output logic                                     o_last_char,
    output logic                                     o_base_invalid
);
    import sitoa_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = i_rst_n;

    sitoa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sitoa_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_number_base (i_cfg_number_base),
        .i_signed_value    (i_signed_value),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_character       (o_character),
        .o_last_char       (o_last_char),
        .o_base_invalid    (o_base_invalid),
        .i_cmd             (cmd),
        .o_status          (status)
    );

endmodule

/* tb/tb_signed_integer_to_ascii_radix_unit.sv */
// Testbench for the signed integer to ASCII radix unit: random and directed values over many radixes.
`timescale 1ns / 100ps

module tb_signed_integer_to_ascii_radix_unit;
    import sitoa_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              inv;
    } t_text_char;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [BASE_W-1:0]             i_cfg_number_base = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic signed [VALUE_WIDTH-1:0] i_signed_value = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic [CHAR_W-1:0]             o_character;
    logic                          o_last_char;
    logic                          o_base_invalid;

    logic [VALUE_WIDTH-1:0] pending_values[$];
    t_text_char             expected_text[$];
    logic [BASE_W-1:0]      active_base = BASE_RESET;
    int                     values_issued = 0;
    int                     values_accepted = 0;
    int                     error_count = 0;
    int                     cycle_count = 0;
    logic                   quiet_tail = 1'b0;

    signed_integer_to_ascii_radix_unit i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_number_base (i_cfg_number_base),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_signed_value    (i_signed_value),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_character       (o_character),
        .o_last_char       (o_last_char),
        .o_base_invalid    (o_base_invalid)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic void predict_text(input logic [VALUE_WIDTH-1:0] val,
                                         input logic [BASE_W-1:0] radix);
        t_text_char             item;
        logic [VALUE_WIDTH-1:0] mag;
        logic [DIGIT_W-1:0]     digs[VALUE_WIDTH];
        logic [CHAR_W-1:0]      c;
        int                     nd;
        if (radix < BASE_MIN || radix > BASE_MAX) begin
            item = '{CHAR_NONE, 1'b1, 1'b1};
            expected_text.push_back(item);
            return;
        end
        mag = val[VALUE_WIDTH-1] ? (~val + 1'b1) : val;
        nd = 0;
        do begin
            digs[nd] = DIGIT_W'(mag % radix);
            nd++;
            mag = mag / radix;
        end while (mag != 0);
        if (val[VALUE_WIDTH-1] && radix == BASE_DEC) begin
            item = '{CHAR_MINUS, 1'b0, 1'b0};
            expected_text.push_back(item);
        end
        for (int i = nd - 1; i >= 0; i--) begin
            c = {{(CHAR_W-DIGIT_W){1'b0}}, digs[i]}
                + ((digs[i] > DIGIT_NINE) ? CHAR_HEX_OFS : CHAR_NUM_OFS);
            item = '{c, (i == 0), 1'b0};
            expected_text.push_back(item);
        end
    endfunction

    // Input driver
    int tx_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (tx_gap > 0) begin
                tx_gap = tx_gap - 1;
                i_in_valid <= 1'b0;
            end else if (!quiet_tail && cycle_count[6] && $urandom_range(0, 7) == 0) begin
                tx_gap = $urandom_range(0, 4);
                i_in_valid <= 1'b0;
            end else if (pending_values.size() > 0) begin
                i_in_valid <= 1'b1;
                i_signed_value <= pending_values.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output ready, with one long hold-off to back the block up
    int   rx_gap = 0;
    int   rx_hold = 0;
    int   chars_seen = 0;
    logic hold_done = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                chars_seen = chars_seen + 1;
            end
            if (rx_hold > 0) begin
                rx_hold = rx_hold - 1;
                i_out_ready <= 1'b0;
            end else if (!hold_done && chars_seen >= 300) begin
                hold_done = 1'b1;
                rx_hold = 400;
                i_out_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap = rx_gap - 1;
                i_out_ready <= 1'b0;
            end else if (!quiet_tail && cycle_count[7] && $urandom_range(0, 5) == 0) begin
                rx_gap = $urandom_range(0, 4);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Monitor and checker
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                active_base = i_cfg_number_base;
            end
            if (i_in_valid && o_in_ready) begin
                predict_text(i_signed_value, active_base);
                values_accepted = values_accepted + 1;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_text.size() == 0) begin
                    $error("unexpected character transaction: %h", o_character);
                    error_count++;
                end else begin
                    want = expected_text.pop_front();
                    if (o_character !== want.ch) begin
                        $error("character: expected %h, got %h", want.ch, o_character);
                        error_count++;
                    end
                    if (o_last_char !== want.last) begin
                        $error("last_char: expected %b, got %b", want.last, o_last_char);
                        error_count++;
                    end
                    if (o_base_invalid !== want.inv) begin
                        $error("base_invalid: expected %b, got %b", want.inv, o_base_invalid);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic queue_value(input logic [VALUE_WIDTH-1:0] v);
        pending_values.push_back(v);
        values_issued++;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (values_accepted != values_issued || expected_text.size() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [BASE_W-1:0] b);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_number_base <= b;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        logic [VALUE_WIDTH-1:0] v;
        case ($urandom_range(0, 7))
            0, 1, 2: v = $urandom;
            3:       v = $urandom_range(0, 300);
            4:       v = -$urandom_range(1, 300);
            5: begin
                case ($urandom_range(0, 4))
                    0:       v = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
                    1:       v = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
                    2:       v = '0;
                    3:       v = '1;
                    default: v = {1'b1, {(VALUE_WIDTH-2){1'b0}}, 1'b1};
                endcase
            end
            6:       v = $urandom >> $urandom_range(0, 31);
            default: v = -($urandom >> $urandom_range(0, 31));
        endcase
        return v;
    endfunction

    function automatic logic [BASE_W-1:0] pick_base();
        int r;
        if ($urandom_range(0, 9) < 8) begin
            return BASE_W'($urandom_range(BASE_MIN, BASE_MAX));
        end
        r = $urandom_range(BASE_MAX + 1, BASE_MAX + 18);
        return BASE_W'(r);
    endfunction

    initial begin
        logic [BASE_W-1:0] radix;
        int                random_sent;
        int                batch;
        int                phase;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_base(BASE_DEC);
        queue_value(32'd0);
        queue_value(32'd1);
        queue_value(-32'sd1);
        queue_value(32'h7FFF_FFFF);
        queue_value(32'h8000_0000);
        queue_value(32'd9);
        queue_value(32'd10);
        queue_value(-32'sd10);
        queue_value(32'h5555_5555);
        queue_value(32'hAAAA_AAAA);
        queue_value(32'd1_000_000_000);
        queue_value(32'h8000_0001);
        wait_idle();

        write_base(BASE_MAX);
        queue_value(32'h0000_0000);
        queue_value(32'hFFFF_FFFF);
        queue_value(32'h8000_0000);
        queue_value(32'h7FFF_FFFF);
        queue_value(32'h00AB_CDEF);
        queue_value(32'h0123_4567);
        queue_value(-32'sd250);
        queue_value(32'd15);
        wait_idle();

        random_sent = 0;
        phase = 0;
        while (random_sent < 450) begin
            case (phase)
                0:       radix = BASE_MIN;
                1:       radix = '0;
                2:       radix = BASE_W'(1);
                3:       radix = BASE_MAX + 1'b1;
                4:       radix = '1;
                default: radix = pick_base();
            endcase
            write_base(radix);
            if (radix < BASE_MIN || radix > BASE_MAX) begin
                batch = $urandom_range(5, 12);
            end else begin
                batch = $urandom_range(20, 50);
            end
            repeat (batch) queue_value(pick_value());
            random_sent += batch;
            phase++;
            wait_idle();
        end

        quiet_tail <= 1'b1;
        write_base(BASE_W'($urandom_range(BASE_MIN, BASE_MAX)));
        repeat (50) queue_value(pick_value());
        wait_idle();

        repeat (50) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
